// ===== sv/assert_macros.svh =====
// Assertion macros for the checker of the sliding window maximum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// The property must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/swm_pkg.sv =====
// Types and constants shared by the sliding window maximum modules.
package swm_pkg;

  localparam int DATA_W = 32;
  localparam int WS_W = 5;
  localparam logic [WS_W-1:0] WS_RESET = 5'd3;
  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     start_sequence;
  } swm_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] window_max;
    logic        [DATA_W-1:0] window_start;
  } swm_out_t;

  // One classified sample on its way from the front to the deque.
  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic        [DATA_W-1:0] pos;
    logic        [DATA_W-1:0] window_start;
    logic                     clear;
    logic                     emit;
  } swm_entry_t;

endpackage

// ===== sv/sliding_window_max.sv =====
// Sliding window maximum over a stream of signed 32-bit samples.
//
// Input channel in_valid/in_stall/in_data carries one sample per transaction;
// start_sequence set empties the candidate queue and gives that sample index 0.
// Output channel out_valid/out_stall/out_data carries the window maximum and
// the index of the window's first sample, once window_size samples (zero read
// as one, capped at WINDOW_MAX) have come in since the last start. cfg_we and
// cfg_wdata write window_size (reset value 3). Throughput is one sample per
// cycle while the receiver does not stall: every deque entry is compared with
// the new sample in parallel, and the two-entry queue keeps the front fed. An
// accepted sample passes through that queue to the deque and its output register.
// When the receiver stalls, the result waits in the output register; samples
// without a result still go through until the next result reaches the head of
// the two-entry queue, and one more sample behind it fills the queue and raises
// in_stall.
// Reset is synchronous: it empties the queue, clears the index and the
// sample count and sets window_size back to 3. No clearing pass is needed.
module sliding_window_max #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [swm_pkg::WS_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  swm_pkg::swm_in_t         in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output swm_pkg::swm_out_t        out_data
);
  import swm_pkg::*;

  localparam int KW = $clog2(WINDOW_MAX + 1);

  logic          fifo_full;
  logic          push;
  swm_entry_t    push_data;
  logic [KW-1:0] k;
  logic          pop;
  swm_entry_t    pop_data;
  logic          not_empty;

  swm_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data),
    .k         (k)
  );

  swm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  swm_deque #(.WINDOW_MAX(WINDOW_MAX)) u_deque (
    .clk       (clk),
    .rst       (rst),
    .k         (k),
    .ent_valid (not_empty),
    .ent       (pop_data),
    .ent_pop   (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/swm_front.sv =====
// Front end: takes samples, assigns positions and decides which ones give a result.
module swm_front #(
  parameter int WINDOW_MAX = 16,
  localparam int KW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [swm_pkg::WS_W-1:0]   cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  swm_pkg::swm_in_t           in_data,
  input  logic                       fifo_full,
  output logic                       push,
  output swm_pkg::swm_entry_t        push_data,
  output logic [KW-1:0]              k
);
  import swm_pkg::*;

  logic [WS_W-1:0]   window_size;
  logic [DATA_W-1:0] sample_index;
  logic [KW-1:0]     sample_count;
  logic [DATA_W-1:0] pos;
  logic [KW-1:0]     count_base;
  logic [KW-1:0]     sample_count_next;

  // Zero means a window of one; sizes above the queue depth saturate.
  always_comb begin
    if (window_size == '0) begin
      k = KW'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      k = KW'(WINDOW_MAX);
    end else begin
      k = KW'(window_size);
    end
  end

  assign in_stall = fifo_full;
  assign push = in_valid && !in_stall;

  always_comb begin
    pos = in_data.start_sequence ? '0 : sample_index;
    count_base = in_data.start_sequence ? '0 : sample_count;
    if (count_base < KW'(WINDOW_MAX)) begin
      sample_count_next = count_base + KW'(1);
    end else begin
      sample_count_next = count_base;
    end
    push_data.sample = in_data.sample;
    push_data.pos = pos;
    push_data.window_start = pos - DATA_W'(k) + DATA_W'(1);
    push_data.clear = in_data.start_sequence;
    push_data.emit = (sample_count_next >= k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WS_RESET;
      sample_index <= '0;
      sample_count <= '0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      if (push) begin
        sample_index <= pos + DATA_W'(1);
        sample_count <= sample_count_next;
      end
    end
  end

endmodule

// ===== sv/swm_fifo.sv =====
// Short queue that decouples the front end from the deque.
module swm_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  swm_pkg::swm_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output swm_pkg::swm_entry_t pop_data,
  output logic                not_empty
);
  import swm_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  swm_entry_t    mem [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full = (count == (AW + 1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (AW + 1)'(1);
        2'b01:   count <= count - (AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/swm_deque.sv =====
// Back end: monotonic deque of candidates and the registered result stage.
module swm_deque #(
  parameter int WINDOW_MAX = 16,
  localparam int KW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [KW-1:0]       k,
  input  logic                ent_valid,
  input  swm_pkg::swm_entry_t ent,
  output logic                ent_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output swm_pkg::swm_out_t   out_data
);
  import swm_pkg::*;

  localparam int D = WINDOW_MAX;

  logic signed [DATA_W-1:0] values [D];
  logic        [DATA_W-1:0] positions [D];
  logic        [KW-1:0]     fill;

  logic signed [DATA_W-1:0] values_next [D];
  logic        [DATA_W-1:0] positions_next [D];
  logic        [KW-1:0]     fill_next;
  logic        [KW-1:0]     fill_eff;
  logic        [KW-1:0]     head;
  logic        [KW-1:0]     tail;
  logic        [KW-1:0]     kept;
  logic        [D-1:0]      stale;
  logic        [D-1:0]      greater;

  // Positions rise and values fall from head to tail, so the stale entries
  // form a prefix and the entries not above the new sample form a suffix.
  always_comb begin
    fill_eff = ent.clear ? '0 : fill;
    for (int j = 0; j < D; j++) begin
      stale[j] = (KW'(j) < fill_eff) && ((ent.pos - positions[j]) >= DATA_W'(k));
      greater[j] = (KW'(j) < fill_eff) && (values[j] > ent.sample);
    end
    head = KW'(D);
    tail = KW'(D);
    for (int j = D - 1; j >= 0; j--) begin
      if (!stale[j]) begin
        head = KW'(j);
      end
      if (!greater[j]) begin
        tail = KW'(j);
      end
    end
    kept = (tail > head) ? tail - head : '0;
    fill_next = kept + KW'(1);
    for (int j = 0; j < D; j++) begin
      values_next[j] = values[j];
      positions_next[j] = positions[j];
      if (KW'(j) == kept) begin
        values_next[j] = ent.sample;
        positions_next[j] = ent.pos;
      end else begin
        for (int s = 0; s < D; s++) begin
          if (s == j + int'(head)) begin
            values_next[j] = values[s];
            positions_next[j] = positions[s];
          end
        end
      end
    end
  end

  // A sample without a result never waits for the output register.
  assign ent_pop = ent_valid && (!ent.emit || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ent_pop) begin
        fill <= fill_next;
      end
      if (ent_pop && ent.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ent_pop) begin
      values <= values_next;
      positions <= positions_next;
    end
    if (ent_pop && ent.emit) begin
      out_data.window_max <= values_next[0];
      out_data.window_start <= ent.window_start;
    end
  end

endmodule

// ===== sv/swm_checker.sv =====
// Port-level checker for the sliding window maximum block, with its bind.
`include "assert_macros.svh"

module swm_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input swm_pkg::swm_out_t out_data
);
  import swm_pkg::*;

  logic        in_acc;
  logic        out_acc;
  logic [31:0] credit;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Samples accepted minus results delivered; sticks once it saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else if (credit != '1) begin
      credit <= credit + 32'(in_acc) - 32'(out_acc);
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !out_valid, "result valid right after reset")
  `ASSERT_IMPL(a_no_extra, clk, rst, out_acc, credit != '0, "more results than samples")

endmodule

bind sliding_window_max swm_checker u_swm_checker (.*);

// ===== verif/tb.sv =====
// Testbench for the sliding window maximum block: random stream, windowed prediction, checks.
`timescale 1ns / 100ps

module tb;
  import swm_pkg::*;

  localparam int WIN_DEPTH = 16;
  localparam int PHASES = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [WS_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  swm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  swm_out_t out_data;

  // Transactions waiting to be offered, and window results still owed by the block.
  swm_in_t sample_backlog[$];
  swm_out_t expected_maxima[$];

  // Shadow of the block's candidate queue and counters.
  logic signed [DATA_W-1:0] cand_val[WIN_DEPTH];
  logic [DATA_W-1:0] cand_pos[WIN_DEPTH];
  int cand_fill = 0;
  logic [DATA_W-1:0] next_index = '0;
  int seen_count = 0;
  logic [WS_W-1:0] win_size = WS_RESET;

  logic send_gaps = 1'b1;
  logic recv_gaps = 1'b1;
  int mismatches = 0;
  int results_seen = 0;

  sliding_window_max i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  function automatic void drop_oldest();
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      cand_val[i] = cand_val[i + 1];
      cand_pos[i] = cand_pos[i + 1];
    end
    cand_fill--;
  endfunction

  function automatic void track_window_max(input swm_in_t item);
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] pos;
    swm_out_t res;
    if (win_size == 0) span = 1;
    else if (win_size > WIN_DEPTH) span = WIN_DEPTH;
    else span = DATA_W'(win_size);
    if (item.start_sequence) begin
      cand_fill = 0;
      next_index = '0;
      seen_count = 0;
    end
    pos = next_index;
    // Candidates that slid out of the window ending at this sample go first.
    while (cand_fill > 0 && (pos - cand_pos[0]) >= span) drop_oldest();
    while (cand_fill > 0 && $signed(cand_val[cand_fill - 1]) <= $signed(item.sample))
      cand_fill--;
    if (cand_fill >= WIN_DEPTH) drop_oldest();
    cand_val[cand_fill] = item.sample;
    cand_pos[cand_fill] = pos;
    cand_fill++;
    next_index = pos + 1;
    if (seen_count < WIN_DEPTH) seen_count++;
    if (seen_count >= span) begin
      res.window_max = cand_val[0];
      res.window_start = pos - (span - 1);
      expected_maxima.insert(expected_maxima.size(), res);
    end
  endfunction

  // Sender: offers the backlog one transaction at a time, with random gaps between them while send_gaps is set.
  int send_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) track_window_max(in_data);
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          in_data <= sample_backlog[0];
          sample_backlog.delete(0);
          in_valid <= 1'b1;
          send_wait = send_gaps ? $urandom_range(0, 11) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls at random while recv_gaps is set; twice it holds off for a long stretch.
  int recv_wait = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_maxima.size() == 0) begin
          $display("%0t: unexpected result max=%0d start=%0d", $time,
                   out_data.window_max, out_data.window_start);
          mismatches++;
        end else begin
          swm_out_t want;
          want = expected_maxima[0];
          expected_maxima.delete(0);
          if (out_data.window_max !== want.window_max) begin
            $display("%0t: window_max expected %0d, got %0d", $time,
                     want.window_max, out_data.window_max);
            mismatches++;
          end
          if (out_data.window_start !== want.window_start) begin
            $display("%0t: window_start expected %0d, got %0d", $time,
                     want.window_start, out_data.window_start);
            mismatches++;
          end
        end
        if (results_seen == 150 || results_seen == 700) hold_left = 120;
        recv_wait = recv_gaps ? $urandom_range(0, 11) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_sample(input logic [DATA_W-1:0] value, input logic start);
    swm_in_t item;
    item.sample = value;
    item.start_sequence = start;
    sample_backlog.insert(sample_backlog.size(), item);
  endtask

  // Lets the block drain, including a trailing sample without a result, and reports results that never came.
  task automatic wait_idle();
    int cycles;
    cycles = 0;
    while ((sample_backlog.size() != 0 || in_valid || expected_maxima.size() != 0)
           && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (6) @(posedge clk);
    if (expected_maxima.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_maxima.size());
      mismatches += expected_maxima.size();
      expected_maxima.delete();
    end
  endtask

  task automatic write_window(input logic [WS_W-1:0] size);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_size = size;
  endtask

  initial begin
    logic [WS_W-1:0] window_plan[PHASES];
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] trend;
    int pick;
    window_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd15, 5'd4, 5'd16,
                    5'd3, 5'd3};
    window_plan[10] = WS_W'($urandom_range(0, 31));
    window_plan[11] = WS_W'($urandom_range(0, 31));
    trend = $urandom();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset window of three: extremes, equal runs, restarts.
    queue_sample(32'h0000_0000, 1'b1);
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'hFFFF_FFFF, 1'b0);
    queue_sample(32'hFFFF_FFFF, 1'b0);
    queue_sample(32'hFFFF_FFFF, 1'b0);
    for (int i = 5; i >= 1; i--) queue_sample(i, 1'b0);
    queue_sample(32'd1, 1'b0);
    queue_sample(32'd7, 1'b1);
    queue_sample(32'd8, 1'b0);
    queue_sample(32'd9, 1'b0);
    queue_sample(32'd10, 1'b0);
    queue_sample(32'h8000_0000, 1'b1);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h0000_0000, 1'b0);
    queue_sample(32'h0000_0000, 1'b0);
    wait_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      send_gaps <= (phase % 3 != 2);
      recv_gaps <= (phase % 4 != 3);
      // Without a restart the new size takes effect on a stream already in progress.
      write_window(window_plan[phase]);
      for (int n = 0; n < 102; n++) begin
        if (phase % 4 == 1 && $urandom_range(0, 3) != 0) pick = 8;
        else pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2, 3: value = $urandom();
          4, 5, 6: value = $urandom_range(0, 6) - 3;
          7: value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          8: begin
            trend = trend - $urandom_range(0, 3);
            value = trend;
          end
          default: begin
            trend = trend + $urandom_range(0, 3);
            value = trend;
          end
        endcase
        queue_sample(value, ($urandom_range(0, 29) == 0) || (n == 0 && phase % 2 == 1));
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sliding_window_max.f =====
+incdir+sv
sv/swm_pkg.sv
sv/swm_front.sv
sv/swm_fifo.sv
sv/swm_deque.sv
sv/sliding_window_max.sv
sv/swm_checker.sv
verif/tb.sv
